// ----- rtl/core/stack_machine_execute_defines.svh -----
// assertion macros used by the checker of the stack machine core
`ifndef STACK_MACHINE_EXECUTE_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define STM_AST_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define STM_AST_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/stm_pkg.sv -----
package stm_pkg;

	localparam logic [4:0] OP_PUSHG   = 5'd0;
	localparam logic [4:0] OP_PUSHC   = 5'd1;
	localparam logic [4:0] OP_ADD     = 5'd2;
	localparam logic [4:0] OP_SUB     = 5'd3;
	localparam logic [4:0] OP_MUL     = 5'd4;
	localparam logic [4:0] OP_DIV     = 5'd5;
	localparam logic [4:0] OP_EQ      = 5'd6;
	localparam logic [4:0] OP_GT      = 5'd7;
	localparam logic [4:0] OP_LT      = 5'd8;
	localparam logic [4:0] OP_AND     = 5'd9;
	localparam logic [4:0] OP_OR      = 5'd10;
	localparam logic [4:0] OP_NOT     = 5'd11;
	localparam logic [4:0] OP_STORE   = 5'd12;
	localparam logic [4:0] OP_JMP     = 5'd13;
	localparam logic [4:0] OP_JIF     = 5'd14;
	localparam logic [4:0] OP_NADA    = 5'd15;
	localparam logic [4:0] OP_WRITE   = 5'd16;
	localparam logic [4:0] OP_READ    = 5'd17;
	localparam logic [4:0] OP_START   = 5'd18;
	localparam logic [4:0] OP_HALT    = 5'd19;
	localparam logic [4:0] OP_ALLOC   = 5'd20;
	localparam logic [4:0] OP_DEALLOC = 5'd21;

	typedef struct packed {
		logic [4:0]         opcode;
		logic signed [31:0] operand;
		logic signed [31:0] read_value;
	} inst_t;

	typedef struct packed {
		logic               write_valid;
		logic signed [31:0] write_value;
		logic               branch_taken;
		logic [5:0]         target_label;
		logic               halted;
		logic               fault;
	} result_t;

	typedef enum logic [3:0] {
		K_NOP, K_PUSHG, K_PUSHC, K_READ, K_ALU, K_NOT, K_STORE, K_JMP,
		K_JIF, K_WRITE, K_START, K_HALT, K_ALLOC, K_DEALLOC
	} kind_t;

	typedef enum logic [3:0] {
		A_ADD, A_SUB, A_MUL, A_DIV, A_EQ, A_GT, A_LT, A_AND, A_OR
	} alu_t;

	// classified instruction as it sits in the queue
	typedef struct packed {
		kind_t              kind;
		alu_t               alu;
		logic               addr_ok;
		logic               label_ok;
		logic signed [31:0] operand;
		logic signed [31:0] read_value;
	} dec_t;

	typedef enum logic [2:0] {S_IDLE, S_SEC, S_EXE, S_DIV, S_DWB} st_t;

endpackage

// ----- rtl/core/stack_machine_execute.sv -----
// an accepted instruction passes S_IDLE, S_SEC and S_EXE of the sequencer and its
// result is pushed in S_EXE; a divide with a nonzero divisor goes on through S_DIV
// (one quotient bit a cycle) and S_DWB; a new instruction is taken only in S_IDLE,
// while the result queue has room; both stack reads use the word memory's read port
// reset: arst_n clears the stack count, both queues and the sequencer; memory is not cleared
module stack_machine_execute #(
	parameter int MEMORY_DEPTH = 512,
	parameter int DATA_WIDTH = 32,
	parameter int LABEL_COUNT = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  stm_pkg::inst_t   inst,
	output logic             empty,
	input  logic             pop,
	output stm_pkg::result_t result
);
	import stm_pkg::*;

	// front end to instruction queue
	logic q_wr, q_full, q_empty, q_pop;
	dec_t q_wdata, q_head;

	// back end to result queue
	logic res_push, out_full;
	result_t res;

	// decode and operand range checks, one transaction per cycle while the instruction queue is not full
	stm_front #(
		.MEMORY_DEPTH(MEMORY_DEPTH),
		.LABEL_COUNT (LABEL_COUNT)
	) u_front (
		.push  (push),
		.inst  (inst),
		.full  (full),
		.q_full(q_full),
		.q_wr  (q_wr),
		.q_data(q_wdata)
	);

	// short queue so the front keeps accepting while the back executes
	stm_fifo #(
		.T    (dec_t),
		.DEPTH(2)
	) u_iq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (q_wr),
		.wdata (q_wdata),
		.rd    (q_pop),
		.rdata (q_head),
		.full  (q_full),
		.empty (q_empty)
	);

	// sequencer, word memory, stack count and serial divider
	stm_back #(
		.MEMORY_DEPTH(MEMORY_DEPTH),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.out_full(out_full),
		.res_push(res_push),
		.res     (res)
	);

	// results wait here; a stalled consumer blocks execution only once this queue is full
	stm_fifo #(
		.T    (result_t),
		.DEPTH(2)
	) u_rq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_push),
		.wdata (res),
		.rd    (pop),
		.rdata (result),
		.full  (out_full),
		.empty (empty)
	);

endmodule

// ----- rtl/core/stm_fifo.sv -----
module stm_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  T     wdata,
	input  logic rd,
	output T     rdata,
	output logic full,
	output logic empty
);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T               slot_q [DEPTH];
	logic [IW-1:0]  wp_q, rp_q;
	logic [CW-1:0]  cnt_q;
	logic           do_wr, do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == IW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == IW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/stm_front.sv -----
module stm_front #(
	parameter int MEMORY_DEPTH = 512,
	parameter int LABEL_COUNT = 64
) (
	input  logic          push,
	input  stm_pkg::inst_t inst,
	output logic          full,
	input  logic          q_full,
	output logic          q_wr,
	output stm_pkg::dec_t q_data
);
	import stm_pkg::*;

	logic [31:0] opu;

	assign full = q_full;
	assign q_wr = push && !q_full;
	assign opu  = inst.operand;

	always_comb begin
		q_data            = '0;
		q_data.kind       = K_NOP;
		q_data.alu        = A_ADD;
		q_data.operand    = inst.operand;
		q_data.read_value = inst.read_value;
		// range checks on the operand only, stack checks happen in the back end
		q_data.addr_ok    = !inst.operand[31] && (opu < 32'(MEMORY_DEPTH));
		q_data.label_ok   = !inst.operand[31] && (opu < 32'(LABEL_COUNT));
		unique case (inst.opcode)
			OP_PUSHG:   q_data.kind = K_PUSHG;
			OP_PUSHC:   q_data.kind = K_PUSHC;
			OP_ADD:     begin q_data.kind = K_ALU; q_data.alu = A_ADD; end
			OP_SUB:     begin q_data.kind = K_ALU; q_data.alu = A_SUB; end
			OP_MUL:     begin q_data.kind = K_ALU; q_data.alu = A_MUL; end
			OP_DIV:     begin q_data.kind = K_ALU; q_data.alu = A_DIV; end
			OP_EQ:      begin q_data.kind = K_ALU; q_data.alu = A_EQ; end
			OP_GT:      begin q_data.kind = K_ALU; q_data.alu = A_GT; end
			OP_LT:      begin q_data.kind = K_ALU; q_data.alu = A_LT; end
			OP_AND:     begin q_data.kind = K_ALU; q_data.alu = A_AND; end
			OP_OR:      begin q_data.kind = K_ALU; q_data.alu = A_OR; end
			OP_NOT:     q_data.kind = K_NOT;
			OP_STORE:   q_data.kind = K_STORE;
			OP_JMP:     q_data.kind = K_JMP;
			OP_JIF:     q_data.kind = K_JIF;
			OP_NADA:    q_data.kind = K_NOP;
			OP_WRITE:   q_data.kind = K_WRITE;
			OP_READ:    q_data.kind = K_READ;
			OP_START:   q_data.kind = K_START;
			OP_HALT:    q_data.kind = K_HALT;
			OP_ALLOC:   q_data.kind = K_ALLOC;
			OP_DEALLOC: q_data.kind = K_DEALLOC;
			default:    q_data.kind = K_NOP;
		endcase
	end

endmodule

// ----- rtl/core/stm_back.sv -----
module stm_back #(
	parameter int MEMORY_DEPTH = 512,
	parameter int DATA_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  stm_pkg::dec_t    q_head,
	output logic             q_pop,
	input  logic             out_full,
	output logic             res_push,
	output stm_pkg::result_t res
);
	import stm_pkg::*;

	localparam int AW  = $clog2(MEMORY_DEPTH);
	localparam int CW  = $clog2(MEMORY_DEPTH + 1);
	localparam int NW  = ((CW > 32) ? CW : 32) + 2;
	localparam int DCW = $clog2(DATA_WIDTH + 1);
	localparam int DW  = DATA_WIDTH;

	st_t st_q, st_d;
	dec_t ins_q;
	logic [CW-1:0] count_q, count_d, n1, n2;
	logic [DW-1:0] mem [MEMORY_DEPTH];
	logic [AW-1:0] raddr, waddr;
	logic [DW-1:0] wdata, rdata_q, a_q, b, alu_r;
	logic mem_we, take, div_load, flt, div_go, is_full;
	logic signed [63:0] opnd64, rd64;
	logic [63:0] wv64;
	logic signed [NW-1:0] cnt_s, op_s, nn;
	logic [DW-1:0] rem_q, quo_q, dvs_q, rem_sh;
	logic neg_q, ge;
	logic [DCW-1:0] dcnt_q;

	assign n1      = count_q - 1'b1;
	assign n2      = count_q - 2'd2;
	assign b       = rdata_q;
	assign opnd64  = 64'(ins_q.operand);
	assign rd64    = 64'(ins_q.read_value);
	assign wv64    = 64'(a_q);
	assign is_full = (count_q == CW'(MEMORY_DEPTH));
	assign cnt_s   = {{(NW - CW){1'b0}}, count_q};
	assign op_s    = NW'(ins_q.operand);
	assign nn      = (ins_q.kind == K_ALLOC) ? cnt_s + op_s : cnt_s - op_s;
	assign div_go  = (ins_q.kind == K_ALU) && (ins_q.alu == A_DIV) && (b != '0);
	assign rem_sh  = {rem_q[DW-2:0], quo_q[DW-1]};
	assign ge      = (rem_sh >= dvs_q);
	assign q_pop   = take;

	// single read port, registered data
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_comb begin
		if (st_q == S_IDLE) begin
			if (q_head.kind == K_PUSHG) begin
				raddr = q_head.operand[AW-1:0];
			end else if (q_head.kind == K_ALU) begin
				raddr = n2[AW-1:0];
			end else begin
				raddr = n1[AW-1:0];
			end
		end else begin
			raddr = n1[AW-1:0];
		end
	end

	always_comb begin
		unique case (ins_q.kind)
			K_PUSHG:            flt = !ins_q.addr_ok || is_full;
			K_PUSHC, K_READ:    flt = is_full;
			K_ALU:              flt = (count_q < CW'(2));
			K_NOT, K_WRITE:     flt = (count_q == '0);
			K_STORE:            flt = !ins_q.addr_ok || (count_q == '0);
			K_JMP:              flt = !ins_q.label_ok;
			K_JIF:              flt = !ins_q.label_ok || (count_q == '0);
			K_ALLOC, K_DEALLOC: flt = (nn < 0) || (nn > NW'(MEMORY_DEPTH));
			default:            flt = 1'b0;
		endcase
	end

	always_comb begin
		unique case (ins_q.alu)
			A_ADD:   alu_r = a_q + b;
			A_SUB:   alu_r = a_q - b;
			A_MUL:   alu_r = a_q * b;
			A_EQ:    alu_r = {{(DW - 1){1'b0}}, a_q == b};
			A_GT:    alu_r = {{(DW - 1){1'b0}}, $signed(b) < $signed(a_q)};
			A_LT:    alu_r = {{(DW - 1){1'b0}}, $signed(a_q) < $signed(b)};
			A_AND:   alu_r = {{(DW - 1){1'b0}}, (|a_q) && (|b)};
			A_OR:    alu_r = {{(DW - 1){1'b0}}, (|a_q) || (|b)};
			default: alu_r = a_q;
		endcase
	end

	// next state
	always_comb begin
		unique case (st_q)
			S_IDLE:  st_d = take ? S_SEC : S_IDLE;
			S_SEC:   st_d = S_EXE;
			S_EXE:   st_d = (!flt && div_go) ? S_DIV : S_IDLE;
			S_DIV:   st_d = (dcnt_q == DCW'(1)) ? S_DWB : S_DIV;
			S_DWB:   st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		take     = 1'b0;
		mem_we   = 1'b0;
		waddr    = n1[AW-1:0];
		wdata    = a_q;
		res_push = 1'b0;
		res      = '0;
		count_d  = count_q;
		div_load = 1'b0;
		unique case (st_q)
			S_IDLE: take = !q_empty && !out_full;
			S_EXE: begin
				if (flt) begin
					res_push  = 1'b1;
					res.fault = 1'b1;
				end else if (div_go) begin
					div_load = 1'b1;
				end else begin
					res_push = 1'b1;
					unique case (ins_q.kind)
						K_PUSHG: begin
							mem_we  = 1'b1;
							waddr   = count_q[AW-1:0];
							count_d = count_q + 1'b1;
						end
						K_PUSHC: begin
							mem_we  = 1'b1;
							waddr   = count_q[AW-1:0];
							wdata   = opnd64[DW-1:0];
							count_d = count_q + 1'b1;
						end
						K_READ: begin
							mem_we  = 1'b1;
							waddr   = count_q[AW-1:0];
							wdata   = rd64[DW-1:0];
							count_d = count_q + 1'b1;
						end
						K_ALU: begin
							mem_we  = 1'b1;
							waddr   = n2[AW-1:0];
							wdata   = alu_r;
							count_d = n1;
						end
						K_NOT: begin
							mem_we = 1'b1;
							wdata  = {{(DW - 1){1'b0}}, a_q == '0};
						end
						K_STORE: begin
							mem_we  = 1'b1;
							waddr   = ins_q.operand[AW-1:0];
							count_d = n1;
						end
						K_JMP: begin
							res.branch_taken = 1'b1;
							res.target_label = ins_q.operand[5:0];
						end
						K_JIF: begin
							count_d = n1;
							if (a_q == '0) begin
								res.branch_taken = 1'b1;
								res.target_label = ins_q.operand[5:0];
							end
						end
						K_WRITE: begin
							res.write_valid = 1'b1;
							res.write_value = wv64[31:0];
							count_d         = n1;
						end
						K_START:            count_d = '0;
						K_HALT:             res.halted = 1'b1;
						K_ALLOC, K_DEALLOC: count_d = nn[CW-1:0];
						default:            count_d = count_q;
					endcase
				end
			end
			S_DWB: begin
				res_push = 1'b1;
				mem_we   = 1'b1;
				waddr    = n2[AW-1:0];
				wdata    = neg_q ? (~quo_q + 1'b1) : quo_q;
				count_d  = n1;
			end
			default: take = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ins_q <= q_head;
		end
		if (st_q == S_SEC) begin
			a_q <= rdata_q;
		end
		if (div_load) begin
			rem_q  <= '0;
			quo_q  <= a_q[DW-1] ? (~a_q + 1'b1) : a_q;
			dvs_q  <= b[DW-1] ? (~b + 1'b1) : b;
			neg_q  <= a_q[DW-1] ^ b[DW-1];
			dcnt_q <= DCW'(DW);
		end else if (st_q == S_DIV) begin
			// one restoring step per cycle
			rem_q  <= ge ? (rem_sh - dvs_q) : rem_sh;
			quo_q  <= {quo_q[DW-2:0], ge};
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			count_q <= '0;
		end else begin
			st_q    <= st_d;
			count_q <= count_d;
		end
	end

endmodule

// ----- rtl/core/stm_checker.sv -----
`include "stack_machine_execute_defines.svh"

module stm_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             empty,
	input logic             pop,
	input stm_pkg::result_t result
);
	import stm_pkg::*;

	`STM_AST_IMP(a_fault_alone, !empty && result.fault, !result.write_valid && !result.branch_taken && !result.halted && result.write_value == 0, "fault result carries other flags")
	`STM_AST_IMP(a_one_kind, !empty, !(result.write_valid && result.branch_taken) && !(result.write_valid && result.halted) && !(result.branch_taken && result.halted), "result reports more than one event")
	`STM_AST_IMP(a_zero_fields, !empty && !result.branch_taken && !result.write_valid, result.target_label == 0 && result.write_value == 0, "inactive result fields not zero")
	`STM_AST_NXT(a_hold, !empty && !pop, !empty && $stable(result), "waiting result changed")

endmodule

bind stack_machine_execute stm_checker u_stm_checker (.*);

// ----- tb/tb_stack_machine_execute.sv -----
module tb_stack_machine_execute;
	timeunit 1ns;
	timeprecision 1ps;
	import stm_pkg::*;

	localparam int DEPTH = 512;
	localparam int LABELS = 64;
	localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
	localparam logic signed [31:0] MOST_POS = 32'sh7fff_ffff;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    full;
	inst_t   inst = '0;
	logic    empty;
	logic    pop = 1'b0;
	result_t result;

	stack_machine_execute u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .inst(inst),
		.empty(empty), .pop(pop), .result(result)
	);

	always #4 clk = ~clk;

	// predicted machine state, advanced as each transaction is accepted
	logic [31:0] vm_mem [DEPTH];
	bit          vm_written [DEPTH];
	int          vm_depth;

	result_t expected_results [$];
	int      mismatches;
	int      results_seen;
	int      insts_sent;
	int      faults_seen;
	int      branches_seen;
	bit      no_idle;        // both sides run without gaps while set
	bit      hold_request;   // asks the result side for a long hold-off

	// true when executing i would touch a memory word that was never written
	function automatic bit touches_unwritten(inst_t i);
		bit addr_ok;
		addr_ok = i.operand >= 0 && i.operand < DEPTH;
		case (i.opcode)
			OP_PUSHG:
				return addr_ok && vm_depth < DEPTH && !vm_written[i.operand];
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_GT, OP_LT, OP_AND, OP_OR:
				return vm_depth >= 2 && (!vm_written[vm_depth-2] || !vm_written[vm_depth-1]);
			OP_NOT, OP_WRITE:
				return vm_depth >= 1 && !vm_written[vm_depth-1];
			OP_STORE:
				return addr_ok && vm_depth >= 1 && !vm_written[vm_depth-1];
			OP_JIF:
				return i.operand >= 0 && i.operand < LABELS && vm_depth >= 1
					&& !vm_written[vm_depth-1];
			default: return 1'b0;
		endcase
	endfunction

	function automatic void vm_put(int a, logic [31:0] v);
		vm_mem[a] = v;
		vm_written[a] = 1'b1;
	endfunction

	// executes one instruction on the predicted state and returns its result
	function automatic result_t execute_inst(inst_t i);
		result_t r;
		bit addr_ok, label_ok;
		logic signed [31:0] a, b, q;
		longint nn;
		r = '0;
		addr_ok = i.operand >= 0 && i.operand < DEPTH;
		label_ok = i.operand >= 0 && i.operand < LABELS;
		case (i.opcode)
			OP_PUSHG: begin
				if (!addr_ok || vm_depth >= DEPTH) r.fault = 1'b1;
				else begin
					vm_put(vm_depth, vm_mem[i.operand]);
					vm_depth++;
				end
			end
			OP_PUSHC, OP_READ: begin
				if (vm_depth >= DEPTH) r.fault = 1'b1;
				else begin
					vm_put(vm_depth, i.opcode == OP_PUSHC ? i.operand : i.read_value);
					vm_depth++;
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_GT, OP_LT, OP_AND, OP_OR: begin
				if (vm_depth < 2) r.fault = 1'b1;
				else begin
					a = vm_mem[vm_depth-2];
					b = vm_mem[vm_depth-1];
					case (i.opcode)
						OP_ADD: q = a + b;
						OP_SUB: q = a - b;
						OP_MUL: q = a * b;
						OP_DIV: begin
							// zero divisor leaves the dividend, most negative / -1 wraps
							if (b == 0 || (a == MOST_NEG && b == -1)) q = a;
							else q = a / b;
						end
						OP_EQ:  q = (a == b);
						OP_GT:  q = (a > b);
						OP_LT:  q = (a < b);
						OP_AND: q = (a != 0 && b != 0);
						default: q = (a != 0 || b != 0);
					endcase
					vm_put(vm_depth-2, q);
					vm_depth--;
				end
			end
			OP_NOT: begin
				if (vm_depth < 1) r.fault = 1'b1;
				else vm_put(vm_depth-1, vm_mem[vm_depth-1] == 0);
			end
			OP_STORE: begin
				if (!addr_ok || vm_depth < 1) r.fault = 1'b1;
				else begin
					vm_put(i.operand, vm_mem[vm_depth-1]);
					vm_depth--;
				end
			end
			OP_JMP: begin
				if (!label_ok) r.fault = 1'b1;
				else begin
					r.branch_taken = 1'b1;
					r.target_label = i.operand[5:0];
				end
			end
			OP_JIF: begin
				if (!label_ok || vm_depth < 1) r.fault = 1'b1;
				else begin
					if (vm_mem[vm_depth-1] == 0) begin
						r.branch_taken = 1'b1;
						r.target_label = i.operand[5:0];
					end
					vm_depth--;
				end
			end
			OP_WRITE: begin
				if (vm_depth < 1) r.fault = 1'b1;
				else begin
					r.write_valid = 1'b1;
					r.write_value = vm_mem[vm_depth-1];
					vm_depth--;
				end
			end
			OP_START: vm_depth = 0;
			OP_HALT:  r.halted = 1'b1;
			OP_ALLOC, OP_DEALLOC: begin
				nn = (i.opcode == OP_ALLOC) ? longint'(vm_depth) + i.operand
					: longint'(vm_depth) - i.operand;
				if (nn < 0 || nn > DEPTH) r.fault = 1'b1;
				else vm_depth = int'(nn);
			end
			default: ;
		endcase
		return r;
	endfunction

	// one transaction on the instruction side; push stays high afterwards
	task automatic send_inst(logic [4:0] op, logic signed [31:0] opnd,
			logic signed [31:0] rd = 32'sd0);
		inst_t i;
		i.opcode = op;
		i.operand = opnd;
		i.read_value = rd;
		if (!no_idle && $urandom_range(0, 99) < 25) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		push <= 1'b1;
		inst <= i;
		do @(posedge clk); while (full);
		expected_results.push_back(execute_inst(i));
		insts_sent++;
	endtask

	// result side: random gaps, plus a long counted hold-off on request
	int hold_left = 0;
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (no_idle) begin
			pop <= 1'b1;
		end else begin
			pop <= ($urandom_range(0, 99) >= 25);
		end
	end

	// result checker: each accepted transaction against the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: %p", result);
			end else begin
				want = expected_results.pop_front();
				if (want.fault) faults_seen++;
				if (want.branch_taken) branches_seen++;
				if (result.write_valid !== want.write_valid
						|| result.write_value !== want.write_value
						|| result.branch_taken !== want.branch_taken
						|| result.target_label !== want.target_label
						|| result.halted !== want.halted
						|| result.fault !== want.fault) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d mismatch: expected %p, got %p",
							results_seen, want, result);
				end
			end
		end
	end

	// lets the block drain before moving on
	task automatic drain();
		push <= 1'b0;
		wait (expected_results.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	// push paths, stack limits, globals and the machine-state opcodes
	task automatic test_stack_ops();
		send_inst(OP_WRITE, 0);                 // underflow on empty stack
		send_inst(OP_PUSHC, MOST_NEG);
		send_inst(OP_PUSHC, MOST_POS);
		send_inst(OP_READ, 0, 32'sh5a5a_a5a5);
		send_inst(OP_READ, 0, MOST_NEG);
		send_inst(OP_STORE, 511);               // top global address
		send_inst(OP_STORE, 512);               // bad address
		send_inst(OP_STORE, -1);
		send_inst(OP_PUSHG, 511);
		send_inst(OP_PUSHG, 0);
		send_inst(OP_PUSHG, MOST_NEG);
		send_inst(OP_WRITE, 0);
		send_inst(OP_ALLOC, 600);               // over the top
		send_inst(OP_DEALLOC, 600);             // below zero
		send_inst(OP_ALLOC, 512 - vm_depth);    // exactly full
		send_inst(OP_PUSHC, 7);                 // overflow
		send_inst(OP_READ, 0, 1);
		send_inst(OP_DEALLOC, 512 - 3);
		send_inst(OP_ALLOC, MOST_POS);
		send_inst(OP_DEALLOC, MOST_NEG);
		send_inst(OP_START, 0);
		send_inst(OP_NADA, -1);
		for (int op = 22; op <= 24; op++) send_inst(op[4:0], MOST_POS, -1);
		drain();
	endtask

	// every arithmetic and logic opcode with its corner operands
	task automatic test_alu_ops();
		logic signed [31:0] pairs [10][2] = '{
			'{5, 0}, '{MOST_NEG, -1}, '{-7, 2}, '{7, -2}, '{MOST_POS, 1},
			'{0, 0}, '{MOST_NEG, MOST_POS}, '{-1, -1}, '{3, 0}, '{0, 9}};
		send_inst(OP_ADD, 0);                   // underflow
		send_inst(OP_NOT, 0);
		for (int op = OP_ADD; op <= OP_OR; op++)
			foreach (pairs[k]) begin
				send_inst(OP_PUSHC, pairs[k][0]);
				send_inst(OP_PUSHC, pairs[k][1]);
				send_inst(op[4:0], 0);
				if (k % 2) send_inst(OP_NOT, 0);
				send_inst(OP_WRITE, 0);
			end
		drain();
	endtask

	// jumps, labels at their limits and halt
	task automatic test_control_ops();
		send_inst(OP_JMP, 0);
		send_inst(OP_JMP, 63);
		send_inst(OP_JMP, 64);
		send_inst(OP_JMP, -1);
		send_inst(OP_JIF, 5);                   // empty stack
		send_inst(OP_PUSHC, 0);
		send_inst(OP_JIF, 63);                  // taken
		send_inst(OP_PUSHC, 1);
		send_inst(OP_JIF, 1);                   // not taken
		send_inst(OP_PUSHC, 0);
		send_inst(OP_JIF, 64);                  // bad label, not popped
		send_inst(OP_JIF, MOST_NEG);
		send_inst(OP_WRITE, 0);
		send_inst(OP_HALT, 0);
		send_inst(OP_PUSHC, 42);
		send_inst(OP_WRITE, 0);
		drain();
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return MOST_NEG;
			1: return MOST_POS;
			2: return $urandom_range(0, 3) - 1;
			3: return $urandom_range(0, 20) - 10;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic signed [31:0] pick_index(int limit);
		if ($urandom_range(0, 9) == 0) return pick_value();
		return $urandom_range(0, limit - 1);
	endfunction

	// one random instruction, steered away from reads of unwritten memory
	task automatic send_random_inst();
		int r;
		logic [4:0] op;
		logic signed [31:0] opnd;
		logic [4:0] alu_ops [9] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ,
			OP_GT, OP_LT, OP_AND, OP_OR};
		logic [4:0] idle_ops [4] = '{OP_NADA, 5'd22, 5'd23, 5'd24};
		inst_t i;
		r = $urandom_range(0, 99);
		opnd = pick_value();
		if (r < 20)      op = OP_PUSHC;
		else if (r < 28) op = OP_READ;
		else if (r < 34) begin op = OP_PUSHG; opnd = pick_index(DEPTH); end
		else if (r < 55) op = alu_ops[$urandom_range(0, 8)];
		else if (r < 60) op = OP_NOT;
		else if (r < 66) begin op = OP_STORE; opnd = pick_index(DEPTH); end
		else if (r < 71) begin op = OP_JMP; opnd = pick_index(LABELS); end
		else if (r < 77) begin op = OP_JIF; opnd = pick_index(LABELS); end
		else if (r < 85) op = OP_WRITE;
		else if (r < 88) begin op = OP_ALLOC; opnd = $urandom_range(0, 11) - 3; end
		else if (r < 91) begin op = OP_DEALLOC; opnd = $urandom_range(0, 11) - 3; end
		else if (r < 92) op = OP_START;
		else if (r < 94) op = OP_HALT;
		else if (r < 96) begin op = OP_ALLOC; opnd = pick_value(); end
		else             op = idle_ops[$urandom_range(0, 3)];
		i.opcode = op;
		i.operand = opnd;
		i.read_value = pick_value();
		if (touches_unwritten(i)) i.opcode = OP_PUSHC;
		send_inst(i.opcode, i.operand, i.read_value);
	endtask

	// result side holds off while instructions keep coming, so full must rise
	task automatic test_backpressure();
		hold_request = 1'b1;
		for (int k = 0; k < 120; k++) send_random_inst();
		drain();
	endtask

	task automatic test_random_program(int count);
		for (int k = 0; k < count; k++) begin
			no_idle = (k >= count / 3 && k < count / 2);   // gap-free stretch
			send_random_inst();
		end
		no_idle = 1'b0;
		drain();
	endtask

	initial begin
		vm_depth = 0;
		mismatches = 0;
		results_seen = 0;
		insts_sent = 0;
		faults_seen = 0;
		branches_seen = 0;
		no_idle = 1'b0;
		hold_request = 1'b0;
		foreach (vm_written[k]) vm_written[k] = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_stack_ops();
		test_alu_ops();
		test_control_ops();
		test_backpressure();
		test_random_program(730);
		$display("ran %0d instructions, %0d results checked (%0d faults, %0d branches)",
			insts_sent, results_seen, faults_seen, branches_seen);
		$display("covered every opcode, stack and address limits, divide corners, backpressure");
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("tb_stack_machine_execute: clean");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches,
				expected_results.size());
			$display("tb_stack_machine_execute: errors");
		end
		$finish;
	end

	// watchdog
	initial begin
		#30ms;
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("tb_stack_machine_execute: errors");
		$finish;
	end

endmodule
